// ===== design/atpp_pkg.sv =====
// Shared types and constants for the adaptive threshold peak picker.
package atpp_pkg;

    localparam int unsigned IDX_W = 20;
    localparam logic [IDX_W-1:0] SEEN_LIMIT = 20'hFFFFF;
    localparam logic [4:0] PEAK_CAP = 5'd17;

    // shared multiplier operand and product widths
    localparam int unsigned MUL_AW = 33;
    localparam int unsigned MUL_BW = 18;
    localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

    // register map, one word per register
    typedef enum logic [2:0] {
        REG_HALF_WIDTH    = 3'd0,
        REG_THRESHOLD     = 3'd1,
        REG_DECAY_RATE    = 3'd2,
        REG_RELATIVE_MODE = 3'd3,
        REG_BACK_SPAN     = 3'd4,
        REG_AHEAD_SPAN    = 3'd5,
        REG_RSVD6         = 3'd6,
        REG_RSVD7         = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [4:0]         half_width;
        logic signed [15:0] threshold;
        logic [15:0]        decay_rate;
        logic               relative_mode;
        logic [1:0]         back_span;
        logic [1:0]         ahead_span;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RDX,
        ST_MULB,
        ST_AVU,
        ST_SMAX,
        ST_LVL,
        ST_SSUM,
        ST_CMP,
        ST_PEAK,
        ST_NEXT,
        ST_FLUSH,
        ST_MARK
    } t_state;

endpackage

// ===== design/adaptive_threshold_peak_picker.sv =====
// Top level: sequencer deciding peak centres over the sample history.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | to block  | i_in_valid / o_in_ready    | i_sample, i_final_sample
//  out     | from blk  | o_out_valid / i_out_ready  | o_peak_index, o_is_peak, o_run_end
//  cfg     | to block  | i_psel/i_penable, o_pready | i_paddr, i_pwdata, o_prdata
//
// Deciding one centre scans its window, plus the back and ahead spans in
// relative mode; each sample also passes accept, last check and flush.
// The scans are bound by the single history read port, one entry per cycle.
// Reset is synchronous, active low; no clearing pass is needed.
// The sequencer waits only when a new result needs the output register while
// an earlier one is still unaccepted; no request is taken until a sample is done.
module adaptive_threshold_peak_picker
    import atpp_pkg::*;
#(
    parameter int unsigned MAX_HALF_WIDTH = 16,
    parameter int unsigned HISTORY_DEPTH  = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_sample,
    input  logic               i_final_sample,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [19:0]        o_peak_index,
    output logic               o_is_peak,
    output logic               o_run_end,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [4:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output logic [31:0]        o_prdata,
    output logic               o_pready
);

    localparam int unsigned AW   = $clog2(HISTORY_DEPTH);
    localparam int unsigned WBW  = $clog2(MAX_HALF_WIDTH + 1);
    localparam int unsigned SPW  = WBW + 2;
    localparam int unsigned CNTW = SPW + 1;
    localparam int unsigned SUMW = 16 + CNTW + 1;
    localparam int unsigned PW   = ((AW > SPW) ? AW : SPW) + 2;
    localparam int unsigned JW   = IDX_W + 1;

    t_cfg w_cfg;

    atpp_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_psel   (i_psel),
        .i_penable(i_penable),
        .i_pwrite (i_pwrite),
        .i_paddr  (i_paddr),
        .i_pwdata (i_pwdata),
        .o_prdata (o_prdata),
        .o_cfg    (w_cfg)
    );
    assign o_pready = 1'b1;

    // state
    t_state                    r_state, n_state;
    logic [IDX_W-1:0]          r_seen, n_seen;
    logic [IDX_W-1:0]          r_centre, n_centre;
    logic [AW-1:0]             r_wptr, n_wptr;
    logic [AW-1:0]             r_cptr, n_cptr;
    logic signed [31:0]        r_av, n_av;
    logic                      r_fin, n_fin;
    logic signed [15:0]        r_x, n_x;
    logic signed [MUL_PW-1:0]  r_acc, n_acc;
    logic                      r_fail, n_fail;
    logic [JW-1:0]             r_j, n_j;
    logic [JW-1:0]             r_jend, n_jend;
    logic [AW-1:0]             r_jptr, n_jptr;
    logic                      r_dv, n_dv;
    logic [JW-1:0]             r_dj, n_dj;
    logic signed [SUMW-1:0]    r_sum, n_sum;
    logic [CNTW-1:0]           r_cnt, n_cnt;
    logic                      r_pend_v, n_pend_v;
    logic [IDX_W-1:0]          r_pend_idx, n_pend_idx;
    logic [4:0]                r_peaks, n_peaks;
    logic                      r_out_v, n_out_v;
    logic [IDX_W-1:0]          r_out_idx, n_out_idx;
    logic                      r_out_pk, n_out_pk;
    logic                      r_out_end, n_out_end;

    // memory and multiplier hookup
    logic                      w_we;
    logic [AW-1:0]             w_raddr;
    logic signed [15:0]        w_rdata;
    logic signed [MUL_AW-1:0]  w_mul_a;
    logic signed [MUL_BW-1:0]  w_mul_b;
    logic signed [MUL_PW-1:0]  w_mul_p;

    atpp_hist_mem #(.DEPTH(HISTORY_DEPTH)) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_wptr),
        .i_wdata(i_sample),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    atpp_mul u_mul (
        .i_clk(i_clk),
        .i_a  (w_mul_a),
        .i_b  (w_mul_b),
        .o_p  (w_mul_p)
    );

    // derived window geometry
    logic [WBW-1:0]          w_w;
    logic [SPW-1:0]          w_ahead, w_back, w_look;
    logic [JW-1:0]           w_c, w_seen;
    logic [JW-1:0]           w_lo, w_hi, w_s, w_e;
    logic [SPW-1:0]          w_off_lo, w_off_s;
    logic                    w_out_free;
    logic signed [31:0]      w_xq;
    logic signed [MUL_PW-1:0] w_avsum, w_avsh;
    logic signed [31:0]      w_avnew;
    logic signed [16:0]      w_xmt;

    always_comb begin
        if (w_cfg.half_width == 5'd0) begin
            w_w = WBW'(1);
        end else if ({3'd0, w_cfg.half_width} > 8'(MAX_HALF_WIDTH)) begin
            w_w = WBW'(MAX_HALF_WIDTH);
        end else begin
            w_w = WBW'(w_cfg.half_width);
        end
    end

    assign w_ahead = SPW'(w_cfg.ahead_span) * SPW'(w_w);
    assign w_back  = SPW'(w_cfg.back_span) * SPW'(w_w);
    assign w_look  = (w_ahead < SPW'(w_w)) ? SPW'(w_w) : w_ahead;
    assign w_c     = JW'(r_centre);
    assign w_seen  = JW'(r_seen);

    assign w_off_lo = (w_c > JW'(w_w)) ? SPW'(w_w) : SPW'(r_centre);
    assign w_lo     = w_c - JW'(w_off_lo);
    assign w_hi     = (w_c + JW'(w_w) + JW'(1) < w_seen) ? w_c + JW'(w_w) + JW'(1) : w_seen;
    assign w_off_s  = (w_c > JW'(w_back)) ? w_back : SPW'(r_centre);
    assign w_s      = w_c - JW'(w_off_s);
    assign w_e      = (w_c + JW'(w_ahead) > w_seen) ? w_seen : w_c + JW'(w_ahead);

    assign w_out_free = !r_out_v || i_out_ready;
    assign w_xq       = {r_x, 16'd0};
    assign w_avsum    = r_acc + (w_mul_p <<< 16);
    assign w_avsh     = w_avsum >>> 16;
    assign w_avnew    = (32'(w_avsh) < w_xq) ? w_xq : 32'(w_avsh);
    assign w_xmt      = 17'(r_x) - 17'(w_cfg.threshold);

    // history position of (centre - off), wrapping around the ring
    function automatic logic [AW-1:0] back_ptr(input logic [AW-1:0] base,
                                               input logic [SPW-1:0] off);
        logic [PW-1:0] b;
        logic [PW-1:0] o;
        b = PW'(base);
        o = PW'(off);
        if (o > b) begin
            back_ptr = AW'(b + PW'(HISTORY_DEPTH) - o);
        end else begin
            back_ptr = AW'(b - o);
        end
    endfunction

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
        if (p == AW'(HISTORY_DEPTH - 1)) begin
            inc_ptr = '0;
        end else begin
            inc_ptr = p + AW'(1);
        end
    endfunction

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_seen   <= '0;
            r_centre <= '0;
            r_wptr   <= '0;
            r_cptr   <= '0;
            r_av     <= '0;
            r_fin    <= 1'b0;
            r_fail   <= 1'b0;
            r_j      <= '0;
            r_jend   <= '0;
            r_dv     <= 1'b0;
            r_pend_v <= 1'b0;
            r_peaks  <= '0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seen   <= n_seen;
            r_centre <= n_centre;
            r_wptr   <= n_wptr;
            r_cptr   <= n_cptr;
            r_av     <= n_av;
            r_fin    <= n_fin;
            r_fail   <= n_fail;
            r_j      <= n_j;
            r_jend   <= n_jend;
            r_dv     <= n_dv;
            r_pend_v <= n_pend_v;
            r_peaks  <= n_peaks;
            r_out_v  <= n_out_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_acc      <= n_acc;
        r_jptr     <= n_jptr;
        r_dj       <= n_dj;
        r_sum      <= n_sum;
        r_cnt      <= n_cnt;
        r_pend_idx <= n_pend_idx;
        r_out_idx  <= n_out_idx;
        r_out_pk   <= n_out_pk;
        r_out_end  <= n_out_end;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_seen     = r_seen;
        n_centre   = r_centre;
        n_wptr     = r_wptr;
        n_cptr     = r_cptr;
        n_av       = r_av;
        n_fin      = r_fin;
        n_x        = r_x;
        n_acc      = r_acc;
        n_fail     = r_fail;
        n_j        = r_j;
        n_jend     = r_jend;
        n_jptr     = r_jptr;
        n_dv       = 1'b0;
        n_dj       = r_dj;
        n_sum      = r_sum;
        n_cnt      = r_cnt;
        n_pend_v   = r_pend_v;
        n_pend_idx = r_pend_idx;
        n_peaks    = r_peaks;
        n_out_v    = r_out_v && !i_out_ready;
        n_out_idx  = r_out_idx;
        n_out_pk   = r_out_pk;
        n_out_end  = r_out_end;
        o_in_ready = 1'b0;
        w_we       = 1'b0;
        w_raddr    = r_cptr;
        w_mul_a    = '0;
        w_mul_b    = '0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_fin   = i_final_sample;
                    n_peaks = '0;
                    if (r_seen < SEEN_LIMIT) begin
                        w_we   = 1'b1;
                        n_seen = r_seen + IDX_W'(1);
                        n_wptr = inc_ptr(r_wptr);
                    end
                    n_state = ST_CHECK;
                end
            end
            // is the next centre ready to decide?
            ST_CHECK: begin
                w_raddr = r_cptr;
                if ((w_c < w_seen) && (r_fin || (w_c + JW'(w_look) < w_seen))) begin
                    n_state = ST_RDX;
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            // load centre sample, start d*av (d*x for the first centre)
            ST_RDX: begin
                n_x     = w_rdata;
                w_mul_a = (r_centre == '0) ? MUL_AW'($signed({w_rdata, 16'd0})) :
                                             MUL_AW'(r_av);
                w_mul_b = MUL_BW'({1'b0, w_cfg.decay_rate});
                n_state = ST_MULB;
            end
            // keep d*av, start (1-d)*x
            ST_MULB: begin
                n_acc   = w_mul_p;
                w_mul_a = MUL_AW'(r_x);
                w_mul_b = MUL_BW'(17'd65536 - {1'b0, w_cfg.decay_rate});
                n_state = ST_AVU;
            end
            // running average update, then set up the maximum scan
            ST_AVU: begin
                n_av    = w_avnew;
                n_fail  = (w_avnew != w_xq);
                n_j     = w_lo;
                n_jend  = w_hi;
                n_jptr  = back_ptr(r_cptr, w_off_lo);
                n_state = ST_SMAX;
            end
            // window scan: issue one read, check the previous one
            ST_SMAX: begin
                w_raddr = r_jptr;
                if (r_dv) begin
                    if (((r_dj < w_c) && (w_rdata >= r_x)) ||
                        ((r_dj > w_c) && (w_rdata > r_x))) begin
                        n_fail = 1'b1;
                    end
                end
                if (r_j < r_jend) begin
                    n_dv   = 1'b1;
                    n_dj   = r_j;
                    n_j    = r_j + JW'(1);
                    n_jptr = inc_ptr(r_jptr);
                end else if (!r_dv) begin
                    n_state = ST_LVL;
                end
            end
            // level test selection
            ST_LVL: begin
                if (r_fail) begin
                    n_state = ST_NEXT;
                end else if (w_cfg.relative_mode) begin
                    if (w_e <= w_s) begin
                        n_state = ST_NEXT;
                    end else begin
                        n_j     = w_s;
                        n_jend  = w_e;
                        n_cnt   = CNTW'(w_e - w_s);
                        n_jptr  = back_ptr(r_cptr, w_off_s);
                        n_sum   = '0;
                        n_state = ST_SSUM;
                    end
                end else if (r_x > w_cfg.threshold) begin
                    n_state = ST_PEAK;
                end else begin
                    n_state = ST_NEXT;
                end
            end
            // mean span sum
            ST_SSUM: begin
                w_raddr = r_jptr;
                if (r_dv) begin
                    n_sum = r_sum + SUMW'(w_rdata);
                end
                if (r_j < r_jend) begin
                    n_dv   = 1'b1;
                    n_j    = r_j + JW'(1);
                    n_jptr = inc_ptr(r_jptr);
                end else if (!r_dv) begin
                    w_mul_a = MUL_AW'(w_xmt);
                    w_mul_b = MUL_BW'({1'b0, r_cnt});
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = (w_mul_p > MUL_PW'(r_sum)) ? ST_PEAK : ST_NEXT;
            end
            // hold the newest peak back until its run_end is known
            ST_PEAK: begin
                if (r_peaks >= PEAK_CAP) begin
                    n_state = ST_NEXT;
                end else if (!r_pend_v) begin
                    n_pend_v   = 1'b1;
                    n_pend_idx = r_centre;
                    n_peaks    = r_peaks + 5'd1;
                    n_state    = ST_NEXT;
                end else if (w_out_free) begin
                    n_out_v    = 1'b1;
                    n_out_idx  = r_pend_idx;
                    n_out_pk   = 1'b1;
                    n_out_end  = 1'b0;
                    n_pend_idx = r_centre;
                    n_peaks    = r_peaks + 5'd1;
                    n_state    = ST_NEXT;
                end
            end
            ST_NEXT: begin
                n_centre = r_centre + IDX_W'(1);
                n_cptr   = inc_ptr(r_cptr);
                n_state  = ST_CHECK;
            end
            // release held peak, then end marker on the last sample
            ST_FLUSH: begin
                if (r_pend_v) begin
                    if (w_out_free) begin
                        n_out_v   = 1'b1;
                        n_out_idx = r_pend_idx;
                        n_out_pk  = 1'b1;
                        n_out_end = !r_fin;
                        n_pend_v  = 1'b0;
                    end
                end else if (r_fin) begin
                    n_state = ST_MARK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MARK: begin
                if (w_out_free) begin
                    n_out_v   = 1'b1;
                    n_out_idx = r_seen;
                    n_out_pk  = 1'b0;
                    n_out_end = 1'b1;
                    n_seen    = '0;
                    n_centre  = '0;
                    n_av      = '0;
                    n_wptr    = '0;
                    n_cptr    = '0;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid  = r_out_v;
    assign o_peak_index = r_out_idx;
    assign o_is_peak    = r_out_pk;
    assign o_run_end    = r_out_end;

`ifndef ASSERT_OFF
    a_peak_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peaks <= PEAK_CAP)
        else $error("peak count above cap");
    a_centre_le_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_centre <= r_seen)
        else $error("centre ahead of samples");
    a_idle_no_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_pend_v)
        else $error("held peak left at idle");
    a_marker_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MARK && w_out_free) |=> (r_seen == '0 && r_centre == '0))
        else $error("sequence not cleared after end marker");
`endif

endmodule

// ===== design/atpp_regs.sv =====
// Configuration register bank behind the APB-style port.
module atpp_regs
    import atpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx = t_reg_idx'(i_paddr[4:2]);
    assign w_wr  = i_psel && i_penable && i_pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_width    <= 5'd1;
            r_cfg.threshold     <= 16'sd0;
            r_cfg.decay_rate    <= 16'd0;
            r_cfg.relative_mode <= 1'b0;
            r_cfg.back_span     <= 2'd3;
            r_cfg.ahead_span    <= 2'd1;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_HALF_WIDTH:    r_cfg.half_width    <= i_pwdata[4:0];
                REG_THRESHOLD:     r_cfg.threshold     <= $signed(i_pwdata[15:0]);
                REG_DECAY_RATE:    r_cfg.decay_rate    <= i_pwdata[15:0];
                REG_RELATIVE_MODE: r_cfg.relative_mode <= i_pwdata[0];
                REG_BACK_SPAN:     r_cfg.back_span     <= i_pwdata[1:0];
                REG_AHEAD_SPAN:    r_cfg.ahead_span    <= i_pwdata[1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        o_prdata = 32'd0;
        unique case (w_idx)
            REG_HALF_WIDTH:    o_prdata = {27'd0, r_cfg.half_width};
            REG_THRESHOLD:     o_prdata = {16'd0, r_cfg.threshold};
            REG_DECAY_RATE:    o_prdata = {16'd0, r_cfg.decay_rate};
            REG_RELATIVE_MODE: o_prdata = {31'd0, r_cfg.relative_mode};
            REG_BACK_SPAN:     o_prdata = {30'd0, r_cfg.back_span};
            REG_AHEAD_SPAN:    o_prdata = {30'd0, r_cfg.ahead_span};
            default:           o_prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/atpp_hist_mem.sv =====
// Sample history memory: one write port, one registered read port.
module atpp_hist_mem #(
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic signed [15:0]       i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic signed [15:0]       o_rdata
);

    logic signed [15:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/atpp_mul.sv =====
// Shared signed multiplier with a registered product.
module atpp_mul
    import atpp_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_AW-1:0] i_a,
    input  logic signed [MUL_BW-1:0] i_b,
    output logic signed [MUL_PW-1:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= MUL_PW'(i_a) * MUL_PW'(i_b);
    end

endmodule
